### hdl/tlbsa_pkg.sv
// Package for the two-level bitmap slot allocator.
// Holds sizes, codes, beat structs and the find-first-zero helper.
// No dependencies.
package tlbsa_pkg;

	localparam int NUM_GROUPS      = 16;
	localparam int SLOTS_PER_GROUP = 1024;
	localparam int WORD_W          = 32;
	localparam int WORDS_PER_GROUP = SLOTS_PER_GROUP / WORD_W;
	localparam int MAP_WORDS       = NUM_GROUPS * WORDS_PER_GROUP;
	localparam int GRP_W           = $clog2(NUM_GROUPS);
	localparam int WRD_W           = $clog2(WORDS_PER_GROUP);
	localparam int BIT_W           = $clog2(WORD_W);
	localparam int MAP_AW          = GRP_W + WRD_W;
	localparam int ID_W            = 14;

	localparam logic [WORD_W-1:0] ALL_ONES = {WORD_W{1'b1}};
	localparam logic [WORD_W-1:0] WORD_ONE = {{(WORD_W-1){1'b0}}, 1'b1};

	typedef enum logic {
		KIND_ALLOC = 1'b0,
		KIND_FREE  = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		STAT_ALLOCATED = 2'd0,
		STAT_FREED     = 2'd1,
		STAT_NO_SPACE  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CLEAR,
		S_SCAN,
		S_DRAIN,
		S_DECIDE,
		S_FREE
	} state_t;

	typedef struct packed {
		kind_t            kind;
		logic [ID_W-1:0]  freed_id;
	} req_t;

	typedef struct packed {
		logic [ID_W-1:0]  allocated_id;
		status_t          status;
	} rsp_t;

	function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_W-1:0] v);
		logic [BIT_W-1:0] r;
		r = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (!v[i]) begin
				r = i[BIT_W-1:0];
			end
		end
		return r;
	endfunction

endpackage

### hdl/tlbsa_ram.sv
// Simple dual-port RAM: one write port, one read port, registered read data.
// Generic; no package dependency.
module tlbsa_ram #(
	parameter int DEPTH = 512,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hdl/two_level_bitmap_slot_allocator_top.sv
// Top level of the two-level bitmap slot allocator.
// Uses tlbsa_pkg and tlbsa_ram (the slot bitmap store).
//
// Usage:
//   A command beat (req: kind, freed_id) is taken on a clock edge where start
//   is high and busy is low. Exactly one result beat (rsp: allocated_id,
//   status) follows, shown for one cycle with done high; the receiver cannot
//   stall it. busy may be low in the cycle done is high, so the next command
//   may be taken there.
//   Steps, from accept edge to done cycle:
//     free of slot 0             : no bitmap access
//     free                       : read, write back
//     allocate, no group left    : no bitmap access
//     allocate, new group        : bitmap clear, one word a cycle
//     allocate, open group       : scan of all 32 bitmap words
//                                  through the single read port, then one
//                                  write back
//   A new command is taken only once the current one is done; no overlap.
//   Reset clears the group active/full flags and the control state. The
//   bitmap store is not cleared; a group's words are cleared when it is
//   activated.
module two_level_bitmap_slot_allocator_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  tlbsa_pkg::req_t  req,
	output logic             done,
	output tlbsa_pkg::rsp_t  rsp
);

	import tlbsa_pkg::*;

	state_t                state_q, state_d;
	logic [NUM_GROUPS-1:0] active_q, full_q;
	logic [GRP_W-1:0]      g_q;
	logic [WRD_W-1:0]      w_q;
	logic [BIT_W-1:0]      fb_q;
	logic                  found_q, second_q;
	logic [WRD_W-1:0]      first_w_q;
	logic [WORD_W-1:0]     first_raw_q;
	logic                  rd_vld_s1;
	logic [WRD_W-1:0]      rd_w_s1;
	logic                  done_q;
	rsp_t                  rsp_q;

	logic                  mem_we, mem_re;
	logic [MAP_AW-1:0]     mem_waddr, mem_raddr;
	logic [WORD_W-1:0]     mem_wdata, mem_rdata;

	logic [NUM_GROUPS-1:0] avail, idle_grp;
	logic [GRP_W-1:0]      avail_g, idle_g;
	logic                  id_zero;
	logic [WORD_W-1:0]     seen_s1, seen_first, bit_first, new_seen;
	logic [BIT_W-1:0]      b_first, rsv_b;
	logic                  new_full;
	logic                  resp_vld;
	rsp_t                  resp;

	tlbsa_ram #(
		.DEPTH(MAP_WORDS),
		.WIDTH(WORD_W)
	) u_map (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	assign avail    = active_q & ~full_q;
	assign idle_grp = ~active_q;
	assign id_zero  = (req.freed_id == '0);

	always_comb begin
		avail_g = '0;
		idle_g  = '0;
		for (int i = NUM_GROUPS - 1; i >= 0; i--) begin
			if (avail[i]) begin
				avail_g = i[GRP_W-1:0];
			end
			if (idle_grp[i]) begin
				idle_g = i[GRP_W-1:0];
			end
		end
	end

	// slot 0 of group 0 is reserved and always reads as used
	assign seen_s1 = mem_rdata | (((g_q == '0) && (rd_w_s1 == '0)) ? WORD_ONE : '0);
	assign seen_first = first_raw_q |
		(((g_q == '0) && (first_w_q == '0)) ? WORD_ONE : '0);
	assign b_first   = first_zero(seen_first);
	assign bit_first = WORD_ONE << b_first;
	assign new_seen  = seen_first | bit_first;
	assign new_full  = !second_q && (new_seen == ALL_ONES);
	assign rsv_b     = (g_q == '0) ? BIT_W'(1) : '0;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (req.kind == KIND_FREE) begin
						state_d = id_zero ? S_IDLE : S_FREE;
					end else if (|avail) begin
						state_d = S_SCAN;
					end else if (|idle_grp) begin
						state_d = S_CLEAR;
					end
				end
			end
			S_CLEAR:  state_d = (w_q == {WRD_W{1'b1}}) ? S_IDLE : S_CLEAR;
			S_SCAN:   state_d = (w_q == {WRD_W{1'b1}}) ? S_DRAIN : S_SCAN;
			S_DRAIN:  state_d = S_DECIDE;
			S_DECIDE: state_d = S_IDLE;
			S_FREE:   state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = {g_q, w_q};
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = {g_q, w_q};
		resp_vld  = 1'b0;
		resp      = '{allocated_id: '0, status: STAT_FREED};
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (req.kind == KIND_FREE) begin
						mem_re    = !id_zero;
						mem_raddr = req.freed_id[ID_W-1 -: MAP_AW];
						resp_vld  = id_zero;
					end else if (!(|avail) && !(|idle_grp)) begin
						resp_vld = 1'b1;
						resp     = '{allocated_id: '0, status: STAT_NO_SPACE};
					end
				end
			end
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_wdata = (w_q == '0) ? (WORD_ONE << rsv_b) : '0;
				if (w_q == {WRD_W{1'b1}}) begin
					resp_vld = 1'b1;
					resp     = '{allocated_id: {g_q, {WRD_W{1'b0}}, rsv_b},
						status: STAT_ALLOCATED};
				end
			end
			S_SCAN: begin
				mem_re = 1'b1;
			end
			S_DRAIN: begin
			end
			S_DECIDE: begin
				resp_vld = 1'b1;
				if (found_q) begin
					mem_we    = 1'b1;
					mem_waddr = {g_q, first_w_q};
					mem_wdata = first_raw_q | bit_first;
					resp      = '{allocated_id: {g_q, first_w_q, b_first},
						status: STAT_ALLOCATED};
				end else begin
					resp = '{allocated_id: '0, status: STAT_NO_SPACE};
				end
			end
			S_FREE: begin
				mem_we    = 1'b1;
				mem_wdata = mem_rdata & ~(WORD_ONE << fb_q);
				resp_vld  = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			active_q  <= '0;
			full_q    <= '0;
			done_q    <= 1'b0;
			rd_vld_s1 <= 1'b0;
			found_q   <= 1'b0;
			second_q  <= 1'b0;
		end else begin
			state_q   <= state_d;
			done_q    <= resp_vld;
			rd_vld_s1 <= (state_q == S_SCAN);
			if (state_q == S_IDLE && start && req.kind == KIND_ALLOC) begin
				found_q  <= 1'b0;
				second_q <= 1'b0;
				if (!(|avail) && (|idle_grp)) begin
					active_q[idle_g] <= 1'b1;
					full_q[idle_g]   <= 1'b0;
				end
			end
			if (rd_vld_s1 && (seen_s1 != ALL_ONES)) begin
				if (!found_q) begin
					found_q <= 1'b1;
				end else begin
					second_q <= 1'b1;
				end
			end
			if (state_q == S_DECIDE) begin
				if (!found_q || new_full) begin
					full_q[g_q] <= 1'b1;
				end
			end
			if (state_q == S_FREE) begin
				full_q[g_q] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rsp_q   <= resp;
		rd_w_s1 <= w_q;
		if (state_q == S_IDLE) begin
			if (start && req.kind == KIND_FREE) begin
				g_q  <= req.freed_id[ID_W-1 -: GRP_W];
				w_q  <= req.freed_id[BIT_W +: WRD_W];
				fb_q <= req.freed_id[BIT_W-1:0];
			end else begin
				w_q <= '0;
				if (start) begin
					g_q <= (|avail) ? avail_g : idle_g;
				end
			end
		end else if (state_q == S_CLEAR || state_q == S_SCAN) begin
			w_q <= w_q + 1'b1;
		end
		if (rd_vld_s1 && (seen_s1 != ALL_ONES) && !found_q) begin
			first_w_q   <= rd_w_s1;
			first_raw_q <= mem_rdata;
		end
	end

endmodule
